// ===== hdl/polyphase_fir_resampler_defines.svh =====
// Assertion macros used by the resampler top module.
// No dependencies.
`ifndef POLYPHASE_FIR_RESAMPLER_DEFINES_SVH
`define POLYPHASE_FIR_RESAMPLER_DEFINES_SVH
// implication check, reset disables
`define PFR_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication check
`define PFR_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== hdl/pfr_pkg.sv =====
// Package for the polyphase resampler: types and constants.
// No dependencies.
package pfr_pkg;
  localparam int unsigned COEF_DEPTH_DEF  = 256;
  localparam int unsigned HIST_DEPTH_DEF  = 256;
  localparam int unsigned MAX_UP_DEF      = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COEF_BITS       = 18;
  localparam int unsigned RES_LIMIT       = 16;
  localparam int unsigned MAX_DOWN        = 256;
  localparam int unsigned CFG_BITS        = 9;
  localparam int unsigned ACC_BITS        = 64;

  typedef enum logic [1:0] {
    REG_UP_RATE    = 2'd0,
    REG_DOWN_RATE  = 2'd1,
    REG_COEF_COUNT = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SETUP, ST_DIV, ST_ISSUE, ST_DRAIN, ST_ROUND,
    ST_STEP, ST_STEPDIV, ST_EMIT, ST_WAIT
  } state_t;

  typedef struct packed {
    logic clear_step;   // write zero to one address of both memories
    logic take_item;    // input item accepted
    logic coef_write;
    logic hist_write;
    logic setup;        // latch clamped config, start divide for P
    logic div_step;
    logic tap_start;
    logic tap_issue;
    logic acc_add;
    logic round;
    logic phase_step;   // t += D
    logic pdiv_step;    // subtract U from t
    logic emit;
    logic finish;       // commit phase and skip
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic skip_pending;
    logic div_done;
    logic taps_done;
    logic pdiv_done;
    logic out_full;
    logic last_res;
  } status_t;
endpackage

// ===== hdl/pfr_stream_if.sv =====
// Valid/ready channel with a generic payload.
// No dependencies.
interface pfr_stream_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/pfr_ram.sv =====
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module pfr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/pfr_ctrl.sv =====
// Resampler controller state machine.
// Depends on pfr_pkg.
module pfr_ctrl import pfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_action,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !status.out_full;
        if (in_valid && in_ready) begin
          cmd.take_item = 1'b1;
          if (in_action) begin
            cmd.coef_write = 1'b1;
          end else begin
            cmd.hist_write = 1'b1;
            state_next = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (status.skip_pending) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.tap_start = 1'b1;
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.tap_issue = 1'b1;
        cmd.acc_add = 1'b1;
        if (status.taps_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.phase_step = 1'b1;
        state_next = ST_STEPDIV;
      end
      ST_STEPDIV: begin
        cmd.pdiv_step = 1'b1;
        if (status.pdiv_done) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!status.out_full) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.last_res) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/pfr_dp.sv =====
// Resampler datapath: memories, MAC, phase arithmetic, output register.
// Depends on pfr_pkg and pfr_ram.
module pfr_dp import pfr_pkg::*; #(
  parameter int unsigned COEF_DEPTH  = COEF_DEPTH_DEF,
  parameter int unsigned HIST_DEPTH  = HIST_DEPTH_DEF,
  parameter int unsigned MAX_UP      = MAX_UP_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [4:0]             up_rate,
  input  logic [CFG_BITS-1:0]    down_rate,
  input  logic [CFG_BITS-1:0]    coef_count,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [7:0]             in_coef_index,
  input  logic [COEF_BITS-1:0]   in_coef_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample,
  output logic                   out_last
);
  localparam int unsigned CA = $clog2(COEF_DEPTH);
  localparam int unsigned HA = $clog2(HIST_DEPTH);
  localparam int unsigned CLR = (CA > HA) ? CA : HA;
  localparam int unsigned UB = $clog2(MAX_UP + 1);
  localparam int unsigned KB = 13;  // holds counts up to 8191
  localparam int unsigned TB = 10;  // phase plus D, below 512
  localparam int unsigned NB = 5;

  logic [CLR:0] clr_cnt;
  logic [HA-1:0] hptr;
  logic [7:0]   skip;
  logic [TB-1:0] phase;
  logic [UB-1:0] u;
  logic [KB-1:0] cnt, p, rem;
  logic [TB-1:0] t;
  logic [TB-1:0] adv;
  logic [KB-1:0] j, k;
  logic [HA-1:0] hidx;
  logic          issue_v, issue_ok;
  logic signed [ACC_BITS-1:0] acc;
  logic [NB-1:0] n;
  logic [SAMPLE_BITS-1:0] res;
  logic [UB-1:0] ph_mod;

  function automatic logic signed [ACC_BITS-1:0] round_sat(
      input logic signed [ACC_BITS-1:0] a);
    logic signed [ACC_BITS-1:0] v, q, hi, lo;
    v = a + (ACC_BITS'(1) <<< 16);
    q = v >>> 17;
    hi = (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q;
  endfunction

  // config clamps
  logic [UB-1:0] u_c;
  logic [KB-1:0] cnt_c;
  logic [TB-1:0] d_c;
  always_comb begin
    u_c = UB'(up_rate);
    if (up_rate == 5'd0) u_c = UB'(1);
    else if (32'(up_rate) > MAX_UP) u_c = UB'(MAX_UP);
    if (32'(u_c) > RES_LIMIT) u_c = UB'(RES_LIMIT);
    d_c = TB'(down_rate);
    if (down_rate == '0) d_c = TB'(1);
    else if (32'(down_rate) > MAX_DOWN) d_c = TB'(MAX_DOWN);
    cnt_c = KB'(coef_count);
    if (coef_count == '0) cnt_c = KB'(1);
    else if (32'(coef_count) > COEF_DEPTH) cnt_c = KB'(COEF_DEPTH);
  end

  // memory ports
  logic            c_we, h_we;
  logic [CA-1:0]   c_wa, c_ra;
  logic [HA-1:0]   h_wa, h_ra;
  logic [COEF_BITS-1:0]   c_wd, c_rd;
  logic [SAMPLE_BITS-1:0] h_wd, h_rd;

  always_comb begin
    c_we = cmd.clear_step || cmd.coef_write;
    h_we = cmd.clear_step || cmd.hist_write;
    c_wa = cmd.clear_step ? CA'(clr_cnt) : CA'(in_coef_index);
    c_wd = cmd.clear_step ? '0 : in_coef_value;
    h_wa = cmd.clear_step ? HA'(clr_cnt) : hptr;
    h_wd = cmd.clear_step ? '0 : in_sample;
    c_ra = CA'(k);
    h_ra = hidx;
  end

  pfr_ram #(.WIDTH(COEF_BITS), .DEPTH(COEF_DEPTH)) u_coef (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  pfr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HIST_DEPTH)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      hptr <= '0;
      skip <= '0;
      phase <= '0;
      out_valid <= 1'b0;
      issue_v <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.hist_write) hptr <= hptr + 1'b1;
      if (cmd.finish && !cmd.emit) skip <= skip - 8'd1;
      if (cmd.finish && cmd.emit) begin
        phase <= t;
        skip <= (adv != '0) ? 8'(adv - 1'b1) : 8'd0;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      issue_v <= cmd.tap_issue && (j < p);
    end
  end

  // P = ceil(cnt/u) by repeated subtraction; phase mod u likewise
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      u <= u_c;
      cnt <= cnt_c;
      rem <= cnt_c;
      p <= '0;
      ph_mod <= '0;
      t <= phase;
      n <= '0;
    end
    if (cmd.div_step) begin
      if (rem != '0) begin
        rem <= (rem > KB'(u)) ? rem - KB'(u) : '0;
        if (p < KB'(HIST_DEPTH)) p <= p + 1'b1;
      end
      if (t >= TB'(u)) t <= t - TB'(u);
    end
    if (cmd.tap_start) begin
      j <= '0;
      k <= KB'(t);
      hidx <= hptr - 1'b1;
      acc <= '0;
    end
    if (cmd.tap_issue && (j < p)) begin
      j <= j + 1'b1;
      k <= k + KB'(u);
      hidx <= hidx - 1'b1;
    end
    issue_ok <= (k < cnt);
    if (cmd.acc_add && issue_v && issue_ok) begin
      acc <= acc + ACC_BITS'($signed(c_rd) * $signed(h_rd));
    end
    if (cmd.round) res <= SAMPLE_BITS'(round_sat(acc));
    if (cmd.phase_step) begin
      t <= t + d_c;
      adv <= '0;
    end
    if (cmd.pdiv_step && (t >= TB'(u))) begin
      t <= t - TB'(u);
      adv <= adv + 1'b1;
    end
    if (cmd.emit) begin
      out_sample <= res;
      out_last <= status.last_res;
      n <= n + 1'b1;
    end
  end

  always_comb begin
    status = '0;
    status.clear_done = (clr_cnt == (CLR+1)'((1 << CLR) - 1));
    status.skip_pending = (skip != 8'd0);
    status.div_done = (rem == '0) && (t < TB'(u));
    status.taps_done = (j >= p) && !issue_v;
    status.pdiv_done = (t < TB'(u));
    status.out_full = out_valid && !out_ready;
    status.last_res = (adv != '0) || (32'(n) + 1 >= RES_LIMIT);
  end
endmodule

// ===== hdl/polyphase_fir_resampler.sv =====
// Channel   | Dir | Payload
// in_ch     | in  | action, sample_in, coef_index, coef_value
// out_ch    | out | sample_out, last
// Coefficient transfer: the table is written in idle. Sample transfer: a pending skip is
// only counted down; else a divide finds P = ceil(coef_count/U) (longer if U was lowered
// below the phase), then per result P taps, rounding and (t+D)/U phase subtractions run;
// one MAC, one tap a cycle. After reset, a clearing pass zeroes both memories.
// Output register holds a result while the sink stalls; input waits while it is full.
// Depends on pfr_pkg, pfr_stream_if, pfr_ctrl, pfr_dp.
module polyphase_fir_resampler import pfr_pkg::*; #(
  parameter int unsigned COEF_DEPTH  = COEF_DEPTH_DEF,
  parameter int unsigned HIST_DEPTH  = HIST_DEPTH_DEF,
  parameter int unsigned MAX_UP      = MAX_UP_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  pfr_stream_if.sink          in_ch,
  pfr_stream_if.source        out_ch
);
  `include "polyphase_fir_resampler_defines.svh"
  logic [4:0]          up_rate;
  logic [CFG_BITS-1:0] down_rate, coef_count;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_rate <= 5'd1;
      down_rate <= CFG_BITS'(1);
      coef_count <= CFG_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UP_RATE:    up_rate <= cfg_data[4:0];
        REG_DOWN_RATE:  down_rate <= cfg_data;
        REG_COEF_COUNT: coef_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;

  pfr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_action(in_ch.data[0]),
    .in_ready(in_ready), .status(status), .cmd(cmd));

  pfr_dp #(.COEF_DEPTH(COEF_DEPTH), .HIST_DEPTH(HIST_DEPTH), .MAX_UP(MAX_UP),
           .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .up_rate(up_rate), .down_rate(down_rate), .coef_count(coef_count),
    .in_sample(in_ch.data[SAMPLE_BITS:1]),
    .in_coef_index(in_ch.data[SAMPLE_BITS+8:SAMPLE_BITS+1]),
    .in_coef_value(in_ch.data[SAMPLE_BITS+8+COEF_BITS:SAMPLE_BITS+9]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_sample(out_ch.data[SAMPLE_BITS-1:0]), .out_last(out_ch.data[SAMPLE_BITS]));

  `PFR_ASSERT_IMP(a_no_emit_full, clk, rst, cmd.emit, !(out_ch.valid && !out_ch.ready))
  `PFR_ASSERT_IMP(a_one_take, clk, rst, cmd.take_item, in_ch.valid)
  `PFR_ASSERT_NXT(a_emit_valid, clk, rst, cmd.emit, out_ch.valid)
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for polyphase_fir_resampler: directed table, then random phases.
// Depends on pfr_pkg, pfr_stream_if and the resampler RTL.
module tb import pfr_pkg::*;;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned SETTLE = 64;
  localparam bit ACT_SAMPLE = 1'b0;
  localparam bit ACT_COEF = 1'b1;

  typedef struct packed {
    logic        last;
    logic [15:0] sample_out;
  } res_t;

  typedef struct {
    bit          act;
    logic [15:0] smp;
    logic [7:0]  idx;
    logic [17:0] val;
    bit          typed;
    logic [15:0] exp_out;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  pfr_stream_if #(.W(43)) in_ch ();
  pfr_stream_if #(.W(17)) out_ch ();

  polyphase_fir_resampler uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // model state
  logic signed [15:0] hist_mem [256];
  logic signed [17:0] tap_mem [256];
  logic [7:0] hist_wr;
  int unsigned cur_phase, skips_left;
  logic [4:0] up_reg;
  logic [8:0] down_reg, count_reg;

  res_t pending_out[$];
  int errors = 0, n_items = 0, n_results = 0, idle_cycles = 0;
  int out_stall = 0;
  bit no_idle = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void resample_sample(input logic [15:0] s);
    int unsigned u, d, c, p, t, adv, k, n;
    longint acc, q;
    res_t r;
    hist_mem[hist_wr] = s;
    hist_wr++;
    if (skips_left > 0) begin
      skips_left--;
      return;
    end
    u = (up_reg == 0) ? 1 : (up_reg > 16 ? 16 : up_reg);
    d = (down_reg == 0) ? 1 : (down_reg > 256 ? 256 : down_reg);
    c = (count_reg == 0) ? 1 : (count_reg > 256 ? 256 : count_reg);
    p = (c + u - 1) / u;
    t = cur_phase % u;
    n = 0;
    forever begin
      acc = 0;
      for (int unsigned j = 0; j < p; j++) begin
        k = j * u + t;
        if (k < c)
          acc += longint'(tap_mem[k]) * longint'(hist_mem[8'(hist_wr - 8'd1 - 8'(j))]);
      end
      t += d;
      adv = t / u;
      t = t % u;
      q = (acc + 64'sd65536) >>> 17;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      n++;
      r.sample_out = 16'(q);
      r.last = (adv != 0 || n >= RES_LIMIT);
      pending_out = {pending_out, r};
      if (r.last) break;
    end
    cur_phase = t;
    skips_left = (adv > 0) ? ((adv - 1) & 8'hFF) : 0;
  endfunction

  task automatic send_item(input bit act, input logic [15:0] smp, input logic [7:0] idx,
                           input logic [17:0] val);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= {val, idx, smp, act};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
    if (act == ACT_COEF) tap_mem[idx] = val;
    else resample_sample(smp);
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [8:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_UP_RATE) up_reg = v[4:0];
    else if (idx == REG_DOWN_RATE) down_reg = v;
    else if (idx == REG_COEF_COUNT) count_reg = v;
    @(posedge clk);
  endtask

  // sink side: random stalls, result check
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        res_t got, want;
        got = out_ch.data;
        n_results++;
        if (pending_out.size() == 0) begin
          report($sformatf("unexpected result %h", got));
        end else begin
          want = pending_out.pop_front();
          if (got.sample_out !== want.sample_out)
            report($sformatf("sample_out %h, expected %h", got.sample_out, want.sample_out));
          if (got.last !== want.last)
            report($sformatf("last %b, expected %b", got.last, want.last));
        end
        out_stall = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired, %0d results still expected", pending_out.size());
      $display("Mismatches found");
      $finish;
    end
  end

  row_t dir_rows [18] = '{
    '{ACT_SAMPLE, 16'h1234, 8'd0,   18'd0,     1, 16'h0000},
    '{ACT_COEF,   16'h0,    8'd0,   18'h1FFFF, 0, 16'h0},
    '{ACT_SAMPLE, 16'h7FFF, 8'd0,   18'd0,     1, 16'h7FFF},
    '{ACT_SAMPLE, 16'h8000, 8'd0,   18'd0,     1, 16'h8000},
    '{ACT_COEF,   16'h0,    8'd0,   18'h20000, 0, 16'h0},
    '{ACT_SAMPLE, 16'h8000, 8'd0,   18'd0,     1, 16'h7FFF},
    '{ACT_SAMPLE, 16'h7FFF, 8'd0,   18'd0,     1, 16'h8001},
    '{ACT_SAMPLE, 16'h0000, 8'd0,   18'd0,     1, 16'h0000},
    '{ACT_COEF,   16'h0,    8'd255, 18'h3FFFF, 0, 16'h0},
    '{ACT_SAMPLE, 16'hFFFF, 8'd0,   18'd0,     1, 16'h0001},
    '{ACT_COEF,   16'h0,    8'd0,   18'h00001, 0, 16'h0},
    '{ACT_SAMPLE, 16'h7FFF, 8'd0,   18'd0,     1, 16'h0000},
    '{ACT_SAMPLE, 16'h8000, 8'd0,   18'd0,     1, 16'h0000},
    '{ACT_COEF,   16'h0,    8'd0,   18'h10000, 0, 16'h0},
    '{ACT_SAMPLE, 16'h0001, 8'd0,   18'd0,     1, 16'h0001},
    '{ACT_SAMPLE, 16'hFFFF, 8'd0,   18'd0,     1, 16'h0000},
    '{ACT_SAMPLE, 16'h5555, 8'd0,   18'd0,     0, 16'h0},
    '{ACT_SAMPLE, 16'hAAAA, 8'd0,   18'd0,     0, 16'h0}
  };

  // up, down, count as raw register writes
  logic [8:0] phase_cfg [8][3] = '{
    '{9'd3, 9'd2, 9'd24}, '{9'd2, 9'd3, 9'd16}, '{9'd16, 9'd1, 9'd64},
    '{9'd1, 9'd256, 9'd256}, '{9'd0, 9'd0, 9'd0}, '{9'h1FF, 9'h1FF, 9'h1FF},
    '{9'd5, 9'd7, 9'd40}, '{9'd4, 9'd4, 9'd9}
  };

  initial begin
    int loads, pick;
    logic [15:0] smp;
    res_t r;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    foreach (tap_mem[i]) tap_mem[i] = '0;
    hist_wr = '0;
    cur_phase = 0;
    skips_left = 0;
    up_reg = 5'd1;
    down_reg = 9'd1;
    count_reg = 9'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].act, dir_rows[i].smp, dir_rows[i].idx, dir_rows[i].val);
      if (dir_rows[i].typed) begin
        r.sample_out = dir_rows[i].exp_out;
        r.last = 1'b1;
        pending_out[pending_out.size() - 1] = r;
      end
    end
    drain_and_settle();
    cfg_write(REG_UNUSED, 9'h1FF);

    for (int ph = 0; ph < 8; ph++) begin
      drain_and_settle();
      no_idle = (ph % 3 == 2);
      cfg_write(REG_UP_RATE, phase_cfg[ph][0]);
      cfg_write(REG_DOWN_RATE, phase_cfg[ph][1]);
      cfg_write(REG_COEF_COUNT, phase_cfg[ph][2]);
      loads = (phase_cfg[ph][2] > 12) ? 12 : phase_cfg[ph][2];
      for (int k = 0; k < loads; k++)
        send_item(ACT_COEF, 16'($urandom), 8'($urandom_range(0, phase_cfg[ph][2] - 1)),
                  18'($urandom));
      for (int k = 0; k < 12; k++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          send_item(ACT_COEF, 16'($urandom), 8'($urandom), 18'($urandom));
        end else begin
          case ($urandom_range(0, 5))
            0: smp = 16'h7FFF;
            1: smp = 16'h8000;
            default: smp = 16'($urandom);
          endcase
          send_item(ACT_SAMPLE, smp, 8'($urandom), 18'($urandom));
        end
      end
    end
    no_idle = 1'b0;
    drain_and_settle();

    $display("Run covered %0d input transfers and %0d result transfers over 8 rate settings.",
             n_items, n_results);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
